// File: rtl/assert_macros.svh
// assertion macros used by the rtl sequencer (mo3q_ctrl)
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// same-cycle implication
`define ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/mo3q_pkg.sv
// package with types and constants of the sorting block
`timescale 1ns / 1ps
`default_nettype none

package mo3q_pkg;

    localparam int CAPACITY    = 64;
    localparam int DATA_WIDTH  = 32;
    localparam int VALUE_WIDTH = 32;
    localparam int COUNT_WIDTH = $clog2(CAPACITY + 1);

    typedef logic signed [DATA_WIDTH-1:0]  data_t;
    typedef logic signed [VALUE_WIDTH-1:0] value_t;
    typedef logic [COUNT_WIDTH-1:0]        count_t;

    // operation applied to every cell of the chain in the same cycle
    typedef struct packed {
        logic insert;
        logic shift;
    } mo3q_op_t;

    typedef enum logic {
        ST_LOAD,
        ST_EMIT
    } mo3q_state_t;

    // take the low bits of a port value as a two's complement element
    function automatic data_t to_data(input value_t v);
        return DATA_WIDTH'(v);
    endfunction

    // sign-extend an element to the port width
    function automatic value_t to_value(input data_t d);
        return VALUE_WIDTH'(d);
    endfunction

endpackage

`default_nettype wire

// File: rtl/median_of_three_quicksort_top.sv
// top level: sorting block built from a chain of insertion cells
//
// Usage:
//   Input requests arrive on s_tvalid/s_tready with the element in s_tdata
//   and s_tlast marking the final element of a set. Up to 64 elements are
//   kept; further elements of the same set are discarded and the run is
//   flagged in m_tuser. Each accepted element is inserted into its sorted
//   place in the cell chain in the cycle it is accepted, so loading runs at
//   one request per cycle.
//   After the request with s_tlast, s_tready drops and the sorted set leaves
//   on m_tvalid/m_tready in ascending order, one result per cycle while the
//   receiver is ready, starting in the cycle after the last request; m_tlast
//   marks the final result. Every result moves the whole chain one cell
//   toward its head.
//   A receiver stall holds the head result and the chain in place. Once the
//   final result is taken the block accepts the next set.
//   Reset (aresetn low at a clock edge) empties the chain and clears the
//   count and overflow flag; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module median_of_three_quicksort_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] value
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [31:0] value_res
    output logic             m_tlast,
    output logic [0:0]       m_tuser    // [0] dropped
);

    localparam int N = mo3q_pkg::CAPACITY;

    mo3q_pkg::mo3q_op_t op;
    mo3q_pkg::data_t    new_data;
    mo3q_pkg::data_t    cell_data [N];
    logic [N-1:0]       cell_valid;
    logic [N-1:0]       cell_gt;
    logic               dropped;

    assign new_data = mo3q_pkg::to_data(s_tdata);

    // chain of cells: left neighbor feeds inserts, right neighbor feeds emission
    for (genvar i = 0; i < N; i++) begin : g_cell
        mo3q_pkg::data_t pd;
        mo3q_pkg::data_t nd;
        logic            pg;
        logic            pv;
        logic            nv;

        if (i == 0) begin : g_head
            assign pd = new_data;
            assign pg = 1'b0;
            assign pv = 1'b1;
        end else begin : g_mid
            assign pd = cell_data[i-1];
            assign pg = cell_gt[i-1];
            assign pv = cell_valid[i-1];
        end

        if (i == N - 1) begin : g_tail
            assign nd = '0;
            assign nv = 1'b0;
        end else begin : g_body
            assign nd = cell_data[i+1];
            assign nv = cell_valid[i+1];
        end

        mo3q_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .op         (op),
            .new_data   (new_data),
            .prev_gt    (pg),
            .prev_data  (pd),
            .prev_valid (pv),
            .next_data  (nd),
            .next_valid (nv),
            .gt         (cell_gt[i]),
            .data       (cell_data[i]),
            .valid      (cell_valid[i])
        );
    end

    // sequencer
    mo3q_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tlast    (s_tlast),
        .s_tready   (s_tready),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .head_valid (cell_valid[0]),
        .head_last  (!cell_valid[1]),
        .dropped    (dropped),
        .op         (op)
    );

    // result request comes straight from the chain head register
    assign m_tdata    = mo3q_pkg::to_value(cell_data[0]);
    assign m_tlast    = !cell_valid[1];
    assign m_tuser[0] = dropped;

endmodule

`default_nettype wire

// File: rtl/mo3q_cell.sv
// one cell of the insertion chain: holds one sorted element
`timescale 1ns / 1ps
`default_nettype none

module mo3q_cell (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire mo3q_pkg::mo3q_op_t op,
    input  wire mo3q_pkg::data_t    new_data,
    input  wire logic               prev_gt,
    input  wire mo3q_pkg::data_t    prev_data,
    input  wire logic               prev_valid,
    input  wire mo3q_pkg::data_t    next_data,
    input  wire logic               next_valid,
    output logic                    gt,
    output mo3q_pkg::data_t         data,
    output logic                    valid
);

    mo3q_pkg::data_t data_reg;
    mo3q_pkg::data_t data_next;
    logic            valid_reg;
    logic            valid_next;

    // new element goes at or before this cell when the cell is empty or larger
    assign gt = !valid_reg || (new_data < data_reg);

    // insert: shift right from the insertion point; shift: move toward the head
    always_comb begin
        data_next  = data_reg;
        valid_next = valid_reg;
        if (op.insert) begin
            if (gt) begin
                if (prev_gt) begin
                    data_next  = prev_data;
                    valid_next = prev_valid;
                end else begin
                    data_next  = new_data;
                    valid_next = 1'b1;
                end
            end
        end else if (op.shift) begin
            data_next  = next_data;
            valid_next = next_valid;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign data  = data_reg;
    assign valid = valid_reg;

endmodule

`default_nettype wire

// File: rtl/mo3q_ctrl.sv
// load / emit sequencer with element count and overflow flag
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module mo3q_ctrl (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_tvalid,
    input  wire logic           s_tlast,
    output logic                s_tready,
    output logic                m_tvalid,
    input  wire logic           m_tready,
    input  wire logic           head_valid,
    input  wire logic           head_last,
    output logic                dropped,
    output mo3q_pkg::mo3q_op_t  op
);

    mo3q_pkg::mo3q_state_t state_reg;
    mo3q_pkg::mo3q_state_t state_next;
    mo3q_pkg::count_t      count_reg;
    mo3q_pkg::count_t      count_next;
    logic                  ovf_reg;
    logic                  ovf_next;
    logic                  in_acc;
    logic                  out_acc;
    logic                  full;

    // handshakes taken from the state register, not from the ready/valid outputs
    assign full    = (count_reg == mo3q_pkg::COUNT_WIDTH'(mo3q_pkg::CAPACITY));
    assign in_acc  = s_tvalid && (state_reg == mo3q_pkg::ST_LOAD);
    assign out_acc = (state_reg == mo3q_pkg::ST_EMIT) && head_valid && m_tready;

    // next state, counters and chain operation
    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        op         = '0;
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        unique case (state_reg)
            mo3q_pkg::ST_LOAD: begin
                s_tready = 1'b1;
                if (in_acc) begin
                    if (full) begin
                        ovf_next = 1'b1;
                    end else begin
                        op.insert  = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                    if (s_tlast) begin
                        state_next = mo3q_pkg::ST_EMIT;
                    end
                end
            end
            mo3q_pkg::ST_EMIT: begin
                m_tvalid = head_valid;
                if (out_acc) begin
                    op.shift = 1'b1;
                    if (head_last) begin
                        state_next = mo3q_pkg::ST_LOAD;
                        count_next = '0;
                        ovf_next   = 1'b0;
                    end
                end
            end
            default: begin
                state_next = mo3q_pkg::ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mo3q_pkg::ST_LOAD;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
    end

    assign dropped = ovf_reg;

    `ASSERT_ALWAYS(a_count_bound, aclk, aresetn,
        count_reg <= mo3q_pkg::COUNT_WIDTH'(mo3q_pkg::CAPACITY),
        "element count beyond capacity")
    `ASSERT_IMPL(a_emit_has_data, aclk, aresetn,
        state_reg == mo3q_pkg::ST_EMIT, head_valid,
        "emit state with empty chain head")
    `ASSERT_NEXT(a_run_end_clears, aclk, aresetn, out_acc && head_last,
        (count_reg == '0) && !ovf_reg && (state_reg == mo3q_pkg::ST_LOAD),
        "run end did not clear count and flag")

endmodule

`default_nettype wire

// File: bench/testbench.sv
// testbench for the insertion-chain sorting block: streams sets, checks sorted runs
`timescale 1ns / 1ps

module testbench;

    localparam mo3q_pkg::value_t VAL_MIN = 32'sh8000_0000;
    localparam mo3q_pkg::value_t VAL_MAX = 32'sh7fff_ffff;
    localparam int               ITEM_BUDGET = 130;

    // one element of a sorted run as it should leave the block
    typedef struct {
        mo3q_pkg::value_t value;
        bit               last;
        bit               dropped;
    } sorted_elem_t;

    // keeps the current set in ascending order and queues the runs it must produce
    class sort_checker;
        mo3q_pkg::value_t held_set[$];
        bit               set_overflow;
        sorted_elem_t     pending_run[$];
        int               failures;

        function new();
            set_overflow = 0;
            failures = 0;
        endfunction

        task report_mismatch(input string what);
            $display("mismatch at %0t: %s", $realtime, what);
            failures++;
        endtask

        // accepted request: store in order, or flag when the store is full
        function void note_request(input mo3q_pkg::value_t v, input bit last);
            mo3q_pkg::data_t  d;
            mo3q_pkg::value_t ext;
            int               pos;
            d   = mo3q_pkg::data_t'(v[mo3q_pkg::DATA_WIDTH-1:0]);
            ext = mo3q_pkg::value_t'(d);
            if (held_set.size() < mo3q_pkg::CAPACITY) begin
                pos = held_set.size();
                for (int i = 0; i < held_set.size(); i++) begin
                    if (held_set[i] > ext) begin
                        pos = i;
                        break;
                    end
                end
                held_set.insert(pos, ext);
            end else begin
                set_overflow = 1;
            end
            // the last request releases the whole run
            if (last) begin
                for (int k = 0; k < held_set.size(); k++) begin
                    sorted_elem_t e;
                    e.value   = held_set[k];
                    e.last    = (k == held_set.size() - 1);
                    e.dropped = set_overflow;
                    pending_run.push_back(e);
                end
                held_set.delete();
                set_overflow = 0;
            end
        endfunction

        // accepted result against the oldest waiting element
        task check_result(input mo3q_pkg::value_t v, input bit last, input bit dropped);
            sorted_elem_t e;
            if (pending_run.size() == 0) begin
                report_mismatch($sformatf("unexpected result value %0d", v));
            end else begin
                e = pending_run.pop_front();
                if (v !== e.value)
                    report_mismatch($sformatf("value %0d, wanted %0d", v, e.value));
                if (last !== e.last)
                    report_mismatch($sformatf("tlast %0b, wanted %0b", last, e.last));
                if (dropped !== e.dropped)
                    report_mismatch($sformatf("dropped %0b, wanted %0b", dropped, e.dropped));
            end
        endtask
    endclass

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        s_tlast = 0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [31:0] m_tdata;
    logic        m_tlast;
    logic [0:0]  m_tuser;

    sort_checker      checker_h = new();
    bit               steady = 0;
    int               stall_left = 0;
    int               items_sent = 0;
    mo3q_pkg::value_t prev_value = '0;
    mo3q_pkg::value_t set_buf[$];

    median_of_three_quicksort_top uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    // 12 ns clock
    always #6 aclk = ~aclk;

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // element values: full range, clustered small values, extremes and repeats
    function automatic mo3q_pkg::value_t pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return mo3q_pkg::value_t'($urandom);
        if (r < 75) return mo3q_pkg::value_t'($signed($urandom_range(0, 16)) - 8);
        if (r < 90) begin
            case ($urandom_range(0, 4))
                0: return VAL_MIN;
                1: return VAL_MAX;
                2: return '0;
                3: return -1;
                default: return 1;
            endcase
        end
        return prev_value;
    endfunction

    // alternate between stretches without idling and stretches with gaps
    initial begin
        forever begin
            repeat ($urandom_range(50, 400)) @(posedge aclk);
            steady <= ~steady;
        end
    end

    // receiver stalls
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready <= 0;
        end else if (!steady && $urandom_range(0, 3) == 0) begin
            stall_left <= gap_len();
            m_tready <= 0;
        end else begin
            m_tready <= 1;
        end
    end

    // input side monitor
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready)
            checker_h.note_request(s_tdata, s_tlast);
    end

    // result side monitor
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            checker_h.check_result(m_tdata, m_tlast, m_tuser[0]);
    end

    // one request, with an optional gap before it
    task send_item(input mo3q_pkg::value_t v, input bit last);
        int gap;
        gap = steady ? 0 : gap_len();
        repeat (gap) begin
            @(negedge aclk);
            s_tvalid <= 0;
        end
        @(negedge aclk);
        s_tvalid <= 1;
        s_tdata  <= v;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
        prev_value = v;
    endtask

    task idle_sender();
        @(negedge aclk);
        s_tvalid <= 0;
    endtask

    // hold off until every queued result has been taken
    task drain_results();
        idle_sender();
        while (checker_h.pending_run.size() != 0) @(posedge aclk);
    endtask

    // send set_buf as one set, last flag on its final element
    task send_buf();
        for (int i = 0; i < set_buf.size(); i++)
            send_item(set_buf[i], i == set_buf.size() - 1);
    endtask

    task send_random_set(input int n);
        for (int i = 0; i < n; i++)
            send_item(pick_value(), i == n - 1);
    endtask

    // main sequence
    initial begin
        int n;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;

        // single element, extremes, duplicates, sorted and reversed order
        set_buf = {VAL_MAX};
        send_buf();
        set_buf = {VAL_MIN, VAL_MAX, mo3q_pkg::value_t'(0), mo3q_pkg::value_t'(-1),
                   mo3q_pkg::value_t'(1)};
        send_buf();
        set_buf = {mo3q_pkg::value_t'(5), mo3q_pkg::value_t'(5), mo3q_pkg::value_t'(5),
                   mo3q_pkg::value_t'(5)};
        send_buf();
        drain_results();
        set_buf = {mo3q_pkg::value_t'(-2), mo3q_pkg::value_t'(-1), mo3q_pkg::value_t'(1),
                   mo3q_pkg::value_t'(2)};
        send_buf();
        set_buf = {VAL_MAX, mo3q_pkg::value_t'(100), mo3q_pkg::value_t'(-100), VAL_MIN};
        send_buf();
        set_buf = {mo3q_pkg::value_t'(1), mo3q_pkg::value_t'(0)};
        send_buf();
        drain_results();

        // fill the store, then overflow with the last request itself discarded
        send_random_set(mo3q_pkg::CAPACITY + 1);
        drain_results();

        // small random sets until the item budget is used up
        while (items_sent < ITEM_BUDGET) begin
            n = $urandom_range(1, 10);
            if (n > ITEM_BUDGET - items_sent)
                n = ITEM_BUDGET - items_sent;
            send_random_set(n);
            if ($urandom_range(0, 5) == 0)
                drain_results();
        end

        // wind down
        drain_results();
        repeat (40) @(posedge aclk);
        if (checker_h.failures == 0 && checker_h.pending_run.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // watchdog
    initial begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
